>>> rtl/core/smc_pkg.sv
// Shared constants, types and helper functions for the sprite mask collision block.
// Depends on nothing; every other file of the block but smc_ram imports it.
package smc_pkg;

	localparam int SPRITES    = 16;
	localparam int PICTURES   = 64;
	localparam int MAX_WIDTH  = 32;
	localparam int MAX_HEIGHT = 32;

	localparam int ROW_W    = 32;
	localparam int HIT_BITS = 16;
	localparam int COORD_W  = 20;
	localparam int SPR_W    = $clog2(SPRITES);
	localparam int CAND_W   = $clog2(SPRITES + 1);
	localparam int PIC_W    = $clog2(PICTURES);
	localparam int W_W      = $clog2(MAX_WIDTH + 1);
	localparam int H_W      = $clog2(MAX_HEIGHT + 1);
	localparam int RIDX_W   = $clog2(MAX_HEIGHT);
	localparam int MADDR_W  = $clog2(PICTURES * MAX_HEIGHT);
	localparam int LEN_W    = $clog2(ROW_W + 1);
	localparam int SH_W     = $clog2(ROW_W);
	localparam int PICNUM_W = 14;

	localparam int MODE_FLIP_X = 0;
	localparam int MODE_FLIP_Y = 1;
	localparam int MODE_MASKED = 2;

	typedef enum logic [2:0] {
		CMD_HEADER  = 3'd0,
		CMD_ROW     = 3'd1,
		CMD_SET     = 3'd2,
		CMD_OFF     = 3'd3,
		CMD_COLLIDE = 3'd4
	} cmd_code_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH_ME,
		ST_FORM_ME,
		ST_CAND,
		ST_FETCH_OT,
		ST_FORM_OT,
		ST_OVL,
		ST_PREP,
		ST_RDA,
		ST_RDB,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]      mode;
		logic [15:0]     hot_y;
		logic [15:0]     hot_x;
		logic [H_W-1:0]  h;
		logic [W_W-1:0]  w;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic [W_W-1:0]            w;
		logic [H_W-1:0]            h;
		logic [PIC_W-1:0]          pic;
		logic                      fx;
		logic                      fy;
	} form_t;

	typedef struct packed {
		logic take;
		logic fetch;
		logic fetch_oth;
		logic form_me;
		logic form_oth;
		logic cand_inc;
		logic ovl_load;
		logic prep_load;
		logic rd_b;
		logic py_inc;
		logic set_hit;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic form_ok;
		logic cand_end;
		logic cand_self;
		logic overlap;
		logic row_hit;
		logic row_last;
		logic out_free;
	} dp_stat_t;

	function automatic logic [ROW_W-1:0] rev_row(input logic [ROW_W-1:0] v);
		logic [ROW_W-1:0] r;
		for (int i = 0; i < ROW_W; i++) begin
			r[i] = v[ROW_W-1-i];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/sprite_mask_collision_top.sv
// Top level of the sprite mask collision block: sequencer plus datapath.
// Depends on smc_pkg, smc_ctrl and smc_dp (which uses smc_ram).
//
// One item is one command. Picture header, mask row, set sprite, sprite off and unknown
// commands give no result. A collide item gives exactly one result (any_hit, hit_mask);
// it checks each candidate sprite in the clipped range, and the scan of a candidate stops
// at its first row with a common solid pixel. The tested sprite itself is skipped, as is a
// candidate without a usable picture or one whose rectangle misses. The single read port
// of the mask row memory delivers one row of each of the two pictures in turn, and each
// candidate needs a sprite and a header lookup; a result that is still held at the output
// adds its wait. No new item is taken while a collide query is in progress; a finished
// result waits in an output register, so other commands are taken while it stays
// unclaimed. Mask rows are not cleared at reset: a collide that touches a row never
// written gives an undefined answer.
module sprite_mask_collision_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [5:0]         index,
	input  logic signed [15:0] arg_a,
	input  logic signed [15:0] arg_b,
	input  logic signed [15:0] hot_x,
	input  logic signed [15:0] hot_y,
	input  logic [15:0]        image_word,
	input  logic [2:0]         pic_flags,
	input  logic [31:0]        row_bits,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               any_hit,
	output logic [15:0]        hit_mask
);
	import smc_pkg::*;

	// Commands from the sequencer and status back from the datapath.
	dp_cmd_t  ctl;
	dp_stat_t st;

	smc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st),
		.ctl      (ctl)
	);

	smc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.index      (index),
		.arg_a      (arg_a),
		.arg_b      (arg_b),
		.hot_x      (hot_x),
		.hot_y      (hot_y),
		.image_word (image_word),
		.pic_flags  (pic_flags),
		.row_bits   (row_bits),
		.ctl        (ctl),
		.st         (st),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.any_hit    (any_hit),
		.hit_mask   (hit_mask)
	);

endmodule

>>> rtl/core/smc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module smc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/smc_ctrl.sv
// Sequencer for the sprite mask collision block: accepts commands and walks a collide query.
// Depends on smc_pkg.
module smc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        cmd,
	input  smc_pkg::dp_stat_t st,
	output smc_pkg::dp_cmd_t  ctl
);
	import smc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.take = 1'b1;
					if (cmd == CMD_COLLIDE) begin
						state_d = ST_FETCH_ME;
					end
				end
			end
			ST_FETCH_ME: begin
				ctl.fetch = 1'b1;
				state_d   = ST_FORM_ME;
			end
			ST_FORM_ME: begin
				ctl.form_me = 1'b1;
				state_d     = st.form_ok ? ST_CAND : ST_DONE;
			end
			ST_CAND: begin
				if (st.cand_end) begin
					state_d = ST_DONE;
				end else if (st.cand_self) begin
					ctl.cand_inc = 1'b1;
				end else begin
					state_d = ST_FETCH_OT;
				end
			end
			ST_FETCH_OT: begin
				ctl.fetch     = 1'b1;
				ctl.fetch_oth = 1'b1;
				state_d       = ST_FORM_OT;
			end
			ST_FORM_OT: begin
				ctl.form_oth = 1'b1;
				if (st.form_ok) begin
					state_d = ST_OVL;
				end else begin
					ctl.cand_inc = 1'b1;
					state_d      = ST_CAND;
				end
			end
			ST_OVL: begin
				ctl.ovl_load = 1'b1;
				if (st.overlap) begin
					state_d = ST_PREP;
				end else begin
					ctl.cand_inc = 1'b1;
					state_d      = ST_CAND;
				end
			end
			ST_PREP: begin
				ctl.prep_load = 1'b1;
				state_d       = ST_RDA;
			end
			ST_RDA: begin
				state_d = ST_RDB;
			end
			ST_RDB: begin
				ctl.rd_b = 1'b1;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				if (st.row_hit) begin
					ctl.set_hit  = 1'b1;
					ctl.cand_inc = 1'b1;
					state_d      = ST_CAND;
				end else if (st.row_last) begin
					ctl.cand_inc = 1'b1;
					state_d      = ST_CAND;
				end else begin
					ctl.py_inc = 1'b1;
					state_d    = ST_RDA;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_hit_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.set_hit |-> state_q == ST_CMP && st.row_hit)
		else $error("hit recorded outside a row compare");
	a_hit_back_to_cand: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.set_hit |=> state_q == ST_CAND)
		else $error("no return to candidate scan after a hit");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |-> !in_stall)
		else $error("item taken while stalled");

endmodule

>>> rtl/core/smc_dp.sv
// Datapath of the sprite mask collision block: sprite table, picture headers, mask rows,
// form computation, overlap and row compare, and the result register.
// Depends on smc_pkg and smc_ram.
module smc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         cmd,
	input  logic [5:0]         index,
	input  logic signed [15:0] arg_a,
	input  logic signed [15:0] arg_b,
	input  logic signed [15:0] hot_x,
	input  logic signed [15:0] hot_y,
	input  logic [15:0]        image_word,
	input  logic [2:0]         pic_flags,
	input  logic [31:0]        row_bits,
	input  smc_pkg::dp_cmd_t   ctl,
	output smc_pkg::dp_stat_t  st,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               any_hit,
	output logic [15:0]        hit_mask
);
	import smc_pkg::*;

	// Sprite table
	logic              act_q [SPRITES];
	logic [15:0]       sx_q  [SPRITES];
	logic [15:0]       sy_q  [SPRITES];
	logic [15:0]       img_q [SPRITES];
	logic              pic_vld_q [PICTURES];

	logic [5:0]          idx_q;
	logic [CAND_W-1:0]   cand_q;
	logic [SPR_W-1:0]    hi_q;
	logic                empty_q;
	logic [HIT_BITS-1:0] hit_q;
	logic                any_q;

	logic take_hdr, take_row, take_set, take_off, take_col;
	assign take_hdr = ctl.take && cmd == CMD_HEADER  && int'(index) < PICTURES;
	assign take_row = ctl.take && cmd == CMD_ROW     && int'(index) < PICTURES
		&& arg_a >= 0 && int'(arg_a) < MAX_HEIGHT;
	assign take_set = ctl.take && cmd == CMD_SET     && int'(index) < SPRITES;
	assign take_off = ctl.take && cmd == CMD_OFF     && int'(index) < SPRITES;
	assign take_col = ctl.take && cmd == CMD_COLLIDE;

	logic [CAND_W-1:0] lo;
	always_comb begin
		if (arg_a < 0) begin
			lo = '0;
		end else if (int'(arg_a) >= SPRITES) begin
			lo = CAND_W'(SPRITES);
		end else begin
			lo = arg_a[CAND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SPRITES; i++) begin
				act_q[i] <= 1'b0;
			end
			for (int i = 0; i < PICTURES; i++) begin
				pic_vld_q[i] <= 1'b0;
			end
		end else begin
			if (take_set) begin
				act_q[index[SPR_W-1:0]] <= 1'b1;
			end
			if (take_off) begin
				act_q[index[SPR_W-1:0]] <= 1'b0;
			end
			if (take_hdr) begin
				pic_vld_q[index[PIC_W-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_set) begin
			sx_q[index[SPR_W-1:0]]  <= arg_a;
			sy_q[index[SPR_W-1:0]]  <= arg_b;
			img_q[index[SPR_W-1:0]] <= image_word;
		end
	end

	always_ff @(posedge clk) begin
		if (take_col) begin
			idx_q   <= index;
			cand_q  <= lo;
			empty_q <= arg_b < 0;
			hi_q    <= (int'(arg_b) >= SPRITES - 1) ? SPR_W'(SPRITES - 1) : arg_b[SPR_W-1:0];
		end else if (ctl.cand_inc) begin
			cand_q <= cand_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
			any_q <= 1'b0;
		end else if (take_col) begin
			hit_q <= '0;
			any_q <= 1'b0;
		end else if (ctl.set_hit) begin
			any_q <= 1'b1;
			hit_q <= hit_q | (HIT_BITS'(1) << cand_q);
		end
	end

	assign st.cand_end  = empty_q || cand_q > CAND_W'(hi_q);
	assign st.cand_self = int'(cand_q) == int'(idx_q);

	// Header store
	hdr_t hdr_wr, hdr_rd;
	logic [HDR_W-1:0] hdr_rdata;
	always_comb begin
		hdr_wr.mode  = pic_flags;
		hdr_wr.hot_x = hot_x;
		hdr_wr.hot_y = hot_y;
		if (arg_a < 0) begin
			hdr_wr.w = '0;
		end else if (int'(arg_a) > MAX_WIDTH) begin
			hdr_wr.w = W_W'(MAX_WIDTH);
		end else begin
			hdr_wr.w = arg_a[W_W-1:0];
		end
		if (arg_b < 0) begin
			hdr_wr.h = '0;
		end else if (int'(arg_b) > MAX_HEIGHT) begin
			hdr_wr.h = H_W'(MAX_HEIGHT);
		end else begin
			hdr_wr.h = arg_b[H_W-1:0];
		end
	end

	// Sprite fetch
	logic [SPR_W-1:0]    fsel;
	logic                frange;
	logic [15:0]         fimg;
	logic [PICNUM_W-1:0] fpic;
	logic                fpic_ok;
	logic                sok_s1, hvld_s1;
	logic [15:0]         x_s1, y_s1;
	logic [PIC_W-1:0]    pic_s1;

	assign fsel    = ctl.fetch_oth ? cand_q[SPR_W-1:0] : idx_q[SPR_W-1:0];
	assign frange  = ctl.fetch_oth || int'(idx_q) < SPRITES;
	assign fimg    = img_q[fsel];
	assign fpic    = fimg[PICNUM_W-1:0];
	assign fpic_ok = fpic != '0 && int'(fpic) < PICTURES;

	always_ff @(posedge clk) begin
		if (ctl.fetch) begin
			sok_s1  <= frange && act_q[fsel] && fpic_ok;
			hvld_s1 <= pic_vld_q[fpic[PIC_W-1:0]];
			x_s1    <= sx_q[fsel];
			y_s1    <= sy_q[fsel];
			pic_s1  <= fpic[PIC_W-1:0];
		end
	end

	smc_ram #(.WIDTH(HDR_W), .DEPTH(PICTURES)) u_hdr_ram (
		.clk   (clk),
		.we    (take_hdr),
		.waddr (index[PIC_W-1:0]),
		.wdata (hdr_wr),
		.raddr (fpic[PIC_W-1:0]),
		.rdata (hdr_rdata)
	);

	// Form of the fetched sprite; the hot spot is a signed value.
	form_t f;
	logic signed [COORD_W-1:0] hx, hy, cw, ch;
	assign hdr_rd = hdr_t'(hdr_rdata);
	assign cw     = COORD_W'(hdr_rd.w);
	assign ch     = COORD_W'(hdr_rd.h);
	always_comb begin
		hx = hdr_rd.mode[MODE_FLIP_X] ? cw - COORD_W'($signed(hdr_rd.hot_x))
			: COORD_W'($signed(hdr_rd.hot_x));
		hy = hdr_rd.mode[MODE_FLIP_Y] ? ch - COORD_W'($signed(hdr_rd.hot_y))
			: COORD_W'($signed(hdr_rd.hot_y));
		f.left = COORD_W'($signed(x_s1)) - hx;
		f.top  = COORD_W'($signed(y_s1)) - hy;
		f.w    = hdr_rd.w;
		f.h    = hdr_rd.h;
		f.pic  = pic_s1;
		f.fx   = hdr_rd.mode[MODE_FLIP_X];
		f.fy   = hdr_rd.mode[MODE_FLIP_Y];
	end
	assign st.form_ok = sok_s1 && hvld_s1 && hdr_rd.w != '0 && hdr_rd.h != '0
		&& hdr_rd.mode[MODE_MASKED];

	form_t me_q, ot_q;
	always_ff @(posedge clk) begin
		if (ctl.form_me) begin
			me_q <= f;
		end
		if (ctl.form_oth) begin
			ot_q <= f;
		end
	end

	// Rectangle overlap
	logic signed [COORD_W-1:0] ar, ab, br, bb;
	logic signed [COORD_W-1:0] l_q, r_q, t_q, d_q;
	assign ar = me_q.left + COORD_W'(me_q.w);
	assign ab = me_q.top  + COORD_W'(me_q.h);
	assign br = ot_q.left + COORD_W'(ot_q.w);
	assign bb = ot_q.top  + COORD_W'(ot_q.h);
	assign st.overlap = !(br <= me_q.left || ot_q.left >= ar
		|| bb <= me_q.top || ot_q.top >= ab);

	always_ff @(posedge clk) begin
		if (ctl.ovl_load) begin
			l_q <= (me_q.left > ot_q.left) ? me_q.left : ot_q.left;
			r_q <= (ar < br) ? ar : br;
			t_q <= (me_q.top > ot_q.top) ? me_q.top : ot_q.top;
			d_q <= (ab < bb) ? ab : bb;
		end
	end

	// Column alignment of both masks to the overlap's left edge
	logic signed [COORD_W-1:0] offa, offb, lenc;
	logic [LEN_W-1:0]          len_q;
	logic [SH_W-1:0]           sha_q, shb_q;
	logic signed [COORD_W-1:0] py_q;
	assign offa = l_q - me_q.left;
	assign offb = l_q - ot_q.left;
	assign lenc = r_q - l_q;

	always_ff @(posedge clk) begin
		if (ctl.prep_load) begin
			len_q <= lenc[LEN_W-1:0];
			sha_q <= me_q.fx ? SH_W'(COORD_W'(ROW_W) - COORD_W'(me_q.w) + offa)
				: offa[SH_W-1:0];
			shb_q <= ot_q.fx ? SH_W'(COORD_W'(ROW_W) - COORD_W'(ot_q.w) + offb)
				: offb[SH_W-1:0];
		end
		if (ctl.prep_load) begin
			py_q <= t_q;
		end else if (ctl.py_inc) begin
			py_q <= py_q + 1'b1;
		end
	end

	// Mask row addresses for the current screen row
	logic signed [COORD_W-1:0] rla, rlb;
	logic [RIDX_W-1:0]         rowa, rowb;
	logic [MADDR_W-1:0]        maddr_a, maddr_b, mwaddr;
	logic [ROW_W-1:0]          mask_rdata, mrow_a_q;
	assign rla  = py_q - me_q.top;
	assign rlb  = py_q - ot_q.top;
	assign rowa = me_q.fy ? RIDX_W'(COORD_W'(me_q.h) - 1 - rla) : rla[RIDX_W-1:0];
	assign rowb = ot_q.fy ? RIDX_W'(COORD_W'(ot_q.h) - 1 - rlb) : rlb[RIDX_W-1:0];
	assign maddr_a = MADDR_W'(MADDR_W'(me_q.pic) * MAX_HEIGHT) + MADDR_W'(rowa);
	assign maddr_b = MADDR_W'(MADDR_W'(ot_q.pic) * MAX_HEIGHT) + MADDR_W'(rowb);
	assign mwaddr  = MADDR_W'(MADDR_W'(index[PIC_W-1:0]) * MAX_HEIGHT)
		+ MADDR_W'(arg_a[RIDX_W-1:0]);

	smc_ram #(.WIDTH(ROW_W), .DEPTH(PICTURES * MAX_HEIGHT)) u_mask_ram (
		.clk   (clk),
		.we    (take_row),
		.waddr (mwaddr),
		.wdata (row_bits),
		.raddr (ctl.rd_b ? maddr_b : maddr_a),
		.rdata (mask_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.rd_b) begin
			mrow_a_q <= mask_rdata;
		end
	end

	logic [ROW_W-1:0] al, bl, lenmask;
	assign al      = (me_q.fx ? rev_row(mrow_a_q) : mrow_a_q) >> sha_q;
	assign bl      = (ot_q.fx ? rev_row(mask_rdata) : mask_rdata) >> shb_q;
	assign lenmask = ROW_W'(((ROW_W + 1)'(1)) << len_q) - 1'b1;
	assign st.row_hit  = |(al & bl & lenmask);
	assign st.row_last = (py_q + 1'b1) == d_q;

	// Result register
	logic out_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ctl.finish) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			any_hit  <= any_q;
			hit_mask <= hit_q;
		end
	end

	assign out_valid   = out_v_q;
	assign st.out_free = !out_v_q || !out_stall;

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !out_v_q || !out_stall)
		else $error("result overwritten while still held");
	a_mask_implies_any: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !any_hit |-> hit_mask == '0)
		else $error("hit mask set without any hit");
	a_hit_not_self: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.set_hit |-> !st.cand_self && !st.cand_end)
		else $error("hit recorded for the tested sprite or outside range");

endmodule
